// ----- rtl/encs_pkg.sv -----
`default_nettype none

package encs_pkg;

   localparam int MAX_ROWS_DEF = 256;
   localparam int MAX_COLS_DEF = 16;

   localparam logic [2:0] ACT_MATRIX   = 3'd0;
   localparam logic [2:0] ACT_RESPONSE = 3'd1;
   localparam logic [2:0] ACT_COEF     = 3'd2;
   localparam logic [2:0] ACT_WEIGHT   = 3'd3;
   localparam logic [2:0] ACT_START    = 3'd4;

   localparam logic [1:0] CSR_LAMBDA = 2'd0;
   localparam logic [1:0] CSR_ALPHA  = 2'd1;
   localparam logic [1:0] CSR_ROWS   = 2'd2;
   localparam logic [1:0] CSR_COLS   = 2'd3;

   localparam logic [16:0] ALPHA_ONE = 17'd65536;

   localparam logic signed [63:0] S64MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] S64MIN = 64'sh8000_0000_0000_0000;
   localparam logic signed [47:0] S48MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] S48MIN = 48'sh8000_0000_0000;

   typedef struct packed {
      logic               start;
      logic signed [63:0] a;
      logic signed [31:0] b;
   } mul_req_type;

   typedef struct packed {
      logic        start;
      logic [63:0] m;
      logic [63:0] den;
   } div_req_type;

   function automatic logic [63:0] mag64(input logic signed [63:0] a);
      mag64 = a[63] ? (~a + 64'd1) : a;
   endfunction

   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         sat_add64 = s[64] ? S64MIN : S64MAX;
      end else begin
         sat_add64 = s[63:0];
      end
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [64:0] s);
      if ((s[64:47] == '0) || (s[64:47] == '1)) begin
         sat48 = s[47:0];
      end else begin
         sat48 = s[64] ? S48MIN : S48MAX;
      end
   endfunction

endpackage

`default_nettype wire

// ----- rtl/encs_mulq.sv -----
`default_nettype none

module encs_mulq (
   input  logic                  clock,
   input  logic                  reset,
   input  encs_pkg::mul_req_type mul_req,
   output logic                  mul_done,
   output logic signed [63:0]    mul_p
);
   import encs_pkg::*;

   typedef enum logic [1:0] {M_IDLE, M_HI, M_LO, M_FIN} mstate_type;

   mstate_type         state_ff;
   logic [63:0]        ua_ff;
   logic [31:0]        ub_ff;
   logic               neg_ff;
   logic [63:0]        hi_ff;
   logic [63:0]        lo_ff;
   logic               done_ff;
   logic signed [63:0] p_ff;

   logic [31:0] op_a;
   logic [63:0] prod;
   logic [64:0] sum;
   logic [63:0] m_val;
   logic [63:0] ub_full;

   // one 32x32 multiplier, upper half of a first then lower half
   assign op_a    = (state_ff == M_HI) ? ua_ff[63:32] : ua_ff[31:0];
   assign prod    = 64'(op_a) * 64'(ub_ff);
   assign ub_full = mag64({{32{mul_req.b[31]}}, mul_req.b});

   always_comb begin
      sum = {2'b00, hi_ff[46:0], 16'd0} + {17'd0, lo_ff[63:16]};
      if (hi_ff >= 64'h0000_8000_0000_0000) begin
         m_val = S64MAX;
      end else if (sum > {1'b0, S64MAX}) begin
         m_val = S64MAX;
      end else begin
         m_val = sum[63:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            M_IDLE: begin
               if (mul_req.start) begin
                  ua_ff    <= mag64(mul_req.a);
                  ub_ff    <= ub_full[31:0];
                  neg_ff   <= mul_req.a[63] ^ mul_req.b[31];
                  state_ff <= M_HI;
               end
            end
            M_HI: begin
               hi_ff    <= prod;
               state_ff <= M_LO;
            end
            M_LO: begin
               lo_ff    <= prod;
               state_ff <= M_FIN;
            end
            M_FIN: begin
               p_ff     <= neg_ff ? -$signed(m_val) : $signed(m_val);
               done_ff  <= 1'b1;
               state_ff <= M_IDLE;
            end
         endcase
      end
   end

   assign mul_done = done_ff;
   assign mul_p    = p_ff;

endmodule

`default_nettype wire

// ----- rtl/encs_div.sv -----
`default_nettype none

module encs_div (
   input  logic                  clock,
   input  logic                  reset,
   input  encs_pkg::div_req_type div_req,
   output logic                  div_done,
   output logic [32:0]           div_q
);
   import encs_pkg::*;

   typedef enum logic {D_IDLE, D_RUN} dstate_type;

   dstate_type  state_ff;
   logic [79:0] rem_ff;
   logic [95:0] dv_ff;
   logic [5:0]  k_ff;
   logic [31:0] q_ff;
   logic        done_ff;
   logic [32:0] res_ff;

   logic ge;

   assign ge = {16'd0, rem_ff} >= dv_ff;

   // restoring division of m*2^16 by den, one quotient bit a cycle;
   // the first step only checks whether the quotient reaches 2^32
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            D_IDLE: begin
               if (div_req.start) begin
                  rem_ff   <= {div_req.m, 16'd0};
                  dv_ff    <= {div_req.den, 32'd0};
                  k_ff     <= 6'd32;
                  q_ff     <= '0;
                  state_ff <= D_RUN;
               end
            end
            D_RUN: begin
               dv_ff <= dv_ff >> 1;
               k_ff  <= k_ff - 6'd1;
               if (k_ff == 6'd32) begin
                  if (ge) begin
                     res_ff   <= {1'b1, 32'd0};
                     done_ff  <= 1'b1;
                     state_ff <= D_IDLE;
                  end
               end else begin
                  if (ge) begin
                     rem_ff <= rem_ff - dv_ff[79:0];
                  end
                  q_ff <= {q_ff[30:0], ge};
                  if (k_ff == 6'd0) begin
                     res_ff   <= {1'b0, q_ff[30:0], ge};
                     done_ff  <= 1'b1;
                     state_ff <= D_IDLE;
                  end
               end
            end
         endcase
      end
   end

   assign div_done = done_ff;
   assign div_q    = res_ff;

endmodule

`default_nettype wire

// ----- rtl/elastic_net_coordinate_sweep.sv -----
`default_nettype none

// channel    | direction | handshake             | payload
// request    | in        | req_valid / req_ready | action, row_index, col_index, value
// response   | out       | rsp_valid / rsp_ready | coef_index, coef_value, last
// csr        | in        | csr_we                | csr_index, csr_wdata
//
// a start request runs one sweep over n rows and p columns: every product goes
// twice through the shared 32x32 multiplier. req_ready is low for the whole
// sweep. reset clears control only; the stores hold nothing until loaded. a
// response still waiting holds the next coefficient in emit until it is taken.

module elastic_net_coordinate_sweep #(
   parameter int MAX_ROWS = encs_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS = encs_pkg::MAX_COLS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_action,
   input  logic [7:0]         req_row_index,
   input  logic [3:0]         req_col_index,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [3:0]         rsp_coef_index,
   output logic signed [31:0] rsp_coef_value,
   output logic               rsp_last,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   import encs_pkg::*;

   localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int NW  = $clog2(MAX_ROWS + 1);
   localparam int PW  = $clog2(MAX_COLS + 1);
   localparam int AW  = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1;

   typedef enum logic [3:0] {
      S_IDLE, S_L2, S_L2W, S_L1, S_L1W, S_COL, S_RD, S_MUL, S_WAIT, S_PEND,
      S_DEN, S_PEN, S_DIV, S_DIVW, S_EMIT
   } state_type;

   typedef enum logic [2:0] {P_NORM, P_INIT, P_SUB0, P_ADD, P_CORR, P_SUBN} pass_type;

   state_type          state_ff;
   pass_type           pass_ff;
   logic [31:0]        lambda_ff;
   logic [16:0]        alpha_ff;
   logic [8:0]         rows_ff;
   logic [4:0]         cols_ff;
   logic [RIW-1:0]     i_ff;
   logic [CIW-1:0]     j_ff;
   logic signed [63:0] acc_ff;
   logic signed [63:0] l1_ff;
   logic signed [63:0] l2_ff;
   logic signed [63:0] den_ff;
   logic [63:0]        m_ff;
   logic signed [31:0] bnew_ff;
   logic               rsp_valid_ff;
   logic [3:0]         rsp_index_ff;
   logic signed [31:0] rsp_value_ff;
   logic               rsp_last_ff;

   logic signed [31:0] dm_rd_ff;
   logic signed [31:0] resp_rd_ff;
   logic signed [47:0] resid_rd_ff;
   logic signed [31:0] coef_rd_ff;
   logic signed [31:0] w_rd_ff;
   logic signed [63:0] norm_rd_ff;

   logic signed [31:0] dm_mem    [MAX_ROWS*MAX_COLS];
   logic signed [31:0] resp_mem  [MAX_ROWS];
   logic signed [47:0] resid_mem [MAX_ROWS];
   logic signed [31:0] coef_mem  [MAX_COLS];
   logic signed [31:0] w_mem     [MAX_COLS];
   logic signed [63:0] norm_mem  [MAX_COLS];

   logic [NW-1:0]      n_w;
   logic [PW-1:0]      p_w;
   logic [16:0]        alpha_c;
   logic               last_row;
   logic               last_col;
   logic               load_go;
   logic               row_ok;
   logic               col_ok;
   logic [AW-1:0]      ld_addr;
   logic [AW-1:0]      dm_raddr;
   logic               dm_we;
   logic               resp_we;
   logic               w_we;
   logic               coef_we;
   logic [CIW-1:0]     coef_waddr;
   logic signed [31:0] coef_wdata;
   logic               norm_we;
   logic               resid_we;
   logic signed [47:0] resid_in;
   logic               emit_go;
   logic               div_go;
   logic [63:0]        m_in;
   logic signed [31:0] bnew_in;
   logic [63:0]        az;
   logic [63:0]        ap;
   logic [64:0]        msum;

   mul_req_type        mul_req;
   logic               mul_done;
   logic signed [63:0] mul_p;
   div_req_type        div_req;
   logic               div_done;
   logic [32:0]        div_q;

   encs_mulq u_mulq (
      .clock    (clock),
      .reset    (reset),
      .mul_req  (mul_req),
      .mul_done (mul_done),
      .mul_p    (mul_p)
   );

   encs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_done (div_done),
      .div_q    (div_q)
   );

   assign n_w      = (32'(rows_ff) > MAX_ROWS) ? NW'(MAX_ROWS) : NW'(rows_ff);
   assign p_w      = (32'(cols_ff) > MAX_COLS) ? PW'(MAX_COLS) : PW'(cols_ff);
   assign alpha_c  = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;
   assign last_row = (32'(i_ff) + 1) == 32'(n_w);
   assign last_col = (32'(j_ff) + 1) == 32'(p_w);

   assign req_ready = (state_ff == S_IDLE);
   assign load_go   = req_valid && req_ready;
   assign row_ok    = 32'(req_row_index) < MAX_ROWS;
   assign col_ok    = 32'(req_col_index) < MAX_COLS;
   assign ld_addr   = AW'(32'(req_col_index) * MAX_ROWS + 32'(req_row_index));
   assign dm_raddr  = AW'(32'(j_ff) * MAX_ROWS + 32'(i_ff));

   assign dm_we   = load_go && (req_action == ACT_MATRIX) && row_ok && col_ok;
   assign resp_we = load_go && (req_action == ACT_RESPONSE) && row_ok;
   assign w_we    = load_go && (req_action == ACT_WEIGHT) && col_ok;
   assign emit_go = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign coef_we = (load_go && (req_action == ACT_COEF) && col_ok) || emit_go;
   assign coef_waddr = emit_go ? j_ff : CIW'(req_col_index);
   assign coef_wdata = emit_go ? bnew_ff : req_value;
   assign norm_we = (state_ff == S_PEND) && (pass_ff == P_NORM);

   always_comb begin
      resid_we = 1'b0;
      resid_in = resid_rd_ff;
      if ((state_ff == S_MUL) && (pass_ff == P_INIT)) begin
         resid_we = 1'b1;
         resid_in = {{16{resp_rd_ff[31]}}, resp_rd_ff};
      end else if ((state_ff == S_WAIT) && mul_done) begin
         if (pass_ff == P_ADD) begin
            resid_we = 1'b1;
            resid_in = sat48({{17{resid_rd_ff[47]}}, resid_rd_ff} + {mul_p[63], mul_p});
         end else if ((pass_ff == P_SUB0) || (pass_ff == P_SUBN)) begin
            resid_we = 1'b1;
            resid_in = sat48({{17{resid_rd_ff[47]}}, resid_rd_ff} - {mul_p[63], mul_p});
         end
      end
   end

   always_comb begin
      mul_req = '0;
      unique case (state_ff)
         S_L2: begin
            mul_req.start = 1'b1;
            mul_req.a     = {32'd0, lambda_ff};
            mul_req.b     = {15'd0, ALPHA_ONE - alpha_c};
         end
         S_L1: begin
            mul_req.start = 1'b1;
            mul_req.a     = {32'd0, lambda_ff};
            mul_req.b     = {15'd0, alpha_c};
         end
         S_MUL: begin
            mul_req.start = (pass_ff != P_INIT);
            mul_req.a     = {{32{dm_rd_ff[31]}}, dm_rd_ff};
            unique case (pass_ff)
               P_NORM: mul_req.b = dm_rd_ff;
               P_CORR: begin
                  mul_req.a = {{16{resid_rd_ff[47]}}, resid_rd_ff};
                  mul_req.b = dm_rd_ff;
               end
               P_SUBN: mul_req.b = bnew_ff;
               P_INIT, P_SUB0, P_ADD: mul_req.b = coef_rd_ff;
            endcase
         end
         S_DEN: begin
            mul_req.start = 1'b1;
            mul_req.a     = l1_ff;
            mul_req.b     = w_rd_ff;
         end
         default: mul_req = '0;
      endcase
   end

   // soft threshold of |z| by the penalty, saturating when the penalty is negative
   always_comb begin
      az   = mag64(acc_ff);
      ap   = mag64(mul_p);
      msum = {1'b0, az} + {1'b0, ap};
      if (!mul_p[63]) begin
         m_in = (az > 64'(mul_p)) ? (az - 64'(mul_p)) : 64'd0;
      end else begin
         m_in = msum[64] ? '1 : msum[63:0];
      end
   end

   assign div_go        = !den_ff[63] && (den_ff != 0) && (acc_ff != 0) && (m_ff != 0);
   assign div_req.start = (state_ff == S_DIV) && div_go;
   assign div_req.m     = m_ff;
   assign div_req.den   = den_ff;

   always_comb begin
      if (!acc_ff[63]) begin
         bnew_in = (div_q > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(div_q[31:0]);
      end else begin
         bnew_in = (div_q > 33'h0_8000_0000) ? 32'sh8000_0000 : -$signed(div_q[31:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (dm_we) begin
         dm_mem[ld_addr] <= req_value;
      end
      dm_rd_ff <= dm_mem[dm_raddr];
   end

   always_ff @(posedge clock) begin
      if (resp_we) begin
         resp_mem[RIW'(req_row_index)] <= req_value;
      end
      resp_rd_ff <= resp_mem[i_ff];
   end

   always_ff @(posedge clock) begin
      if (resid_we) begin
         resid_mem[i_ff] <= resid_in;
      end
      resid_rd_ff <= resid_mem[i_ff];
   end

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[coef_waddr] <= coef_wdata;
      end
      coef_rd_ff <= coef_mem[j_ff];
   end

   always_ff @(posedge clock) begin
      if (w_we) begin
         w_mem[CIW'(req_col_index)] <= req_value;
      end
      w_rd_ff <= w_mem[j_ff];
   end

   always_ff @(posedge clock) begin
      if (norm_we) begin
         norm_mem[j_ff] <= acc_ff;
      end
      norm_rd_ff <= norm_mem[j_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pass_ff      <= P_NORM;
         rsp_valid_ff <= 1'b0;
         lambda_ff    <= '0;
         alpha_ff     <= ALPHA_ONE;
         rows_ff      <= 9'd256;
         cols_ff      <= 5'd16;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_LAMBDA: lambda_ff <= csr_wdata;
               CSR_ALPHA:  alpha_ff  <= csr_wdata[16:0];
               CSR_ROWS:   rows_ff   <= csr_wdata[8:0];
               CSR_COLS:   cols_ff   <= csr_wdata[4:0];
            endcase
         end
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (load_go && (req_action == ACT_START)) begin
                  state_ff <= S_L2;
               end
            end
            S_L2: state_ff <= S_L2W;
            S_L2W: begin
               if (mul_done) begin
                  l2_ff    <= mul_p;
                  state_ff <= S_L1;
               end
            end
            S_L1: state_ff <= S_L1W;
            S_L1W: begin
               if (mul_done) begin
                  l1_ff   <= mul_p;
                  pass_ff <= P_NORM;
                  j_ff    <= '0;
                  state_ff <= (p_w == 0) ? S_IDLE : S_COL;
               end
            end
            S_COL: begin
               acc_ff   <= '0;
               i_ff     <= '0;
               state_ff <= (n_w == 0) ? S_PEND : S_RD;
            end
            S_RD: state_ff <= S_MUL;
            S_MUL: begin
               if (pass_ff == P_INIT) begin
                  if (last_row) begin
                     state_ff <= S_PEND;
                  end else begin
                     i_ff     <= i_ff + 1'b1;
                     state_ff <= S_RD;
                  end
               end else begin
                  state_ff <= S_WAIT;
               end
            end
            S_WAIT: begin
               if (mul_done) begin
                  if ((pass_ff == P_NORM) || (pass_ff == P_CORR)) begin
                     acc_ff <= sat_add64(acc_ff, mul_p);
                  end
                  if (last_row) begin
                     state_ff <= S_PEND;
                  end else begin
                     i_ff     <= i_ff + 1'b1;
                     state_ff <= S_RD;
                  end
               end
            end
            S_PEND: begin
               unique case (pass_ff)
                  P_NORM: begin
                     if (last_col) begin
                        pass_ff <= P_INIT;
                     end else begin
                        j_ff <= j_ff + 1'b1;
                     end
                     state_ff <= S_COL;
                  end
                  P_INIT: begin
                     pass_ff  <= P_SUB0;
                     j_ff     <= '0;
                     state_ff <= S_COL;
                  end
                  P_SUB0: begin
                     if (last_col) begin
                        pass_ff <= P_ADD;
                        j_ff    <= '0;
                     end else begin
                        j_ff <= j_ff + 1'b1;
                     end
                     state_ff <= S_COL;
                  end
                  P_ADD: begin
                     pass_ff  <= P_CORR;
                     state_ff <= S_COL;
                  end
                  P_CORR: state_ff <= S_DEN;
                  P_SUBN: begin
                     if (last_col) begin
                        state_ff <= S_IDLE;
                     end else begin
                        j_ff     <= j_ff + 1'b1;
                        pass_ff  <= P_ADD;
                        state_ff <= S_COL;
                     end
                  end
               endcase
            end
            S_DEN: begin
               den_ff   <= sat_add64(norm_rd_ff, l2_ff);
               state_ff <= S_PEN;
            end
            S_PEN: begin
               if (mul_done) begin
                  m_ff     <= m_in;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_go) begin
                  state_ff <= S_DIVW;
               end else begin
                  bnew_ff  <= '0;
                  state_ff <= S_EMIT;
               end
            end
            S_DIVW: begin
               if (div_done) begin
                  bnew_ff  <= bnew_in;
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (emit_go) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_index_ff <= 4'(j_ff);
                  rsp_value_ff <= bnew_ff;
                  rsp_last_ff  <= last_col;
                  pass_ff      <= P_SUBN;
                  state_ff     <= S_COL;
               end
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_coef_index = rsp_index_ff;
   assign rsp_coef_value = rsp_value_ff;
   assign rsp_last       = rsp_last_ff;

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_EMIT)
      else $error("response raised outside emit");

   a_mul_done_expected: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == S_WAIT) || (state_ff == S_L2W) ||
                   (state_ff == S_L1W) || (state_ff == S_PEN))
      else $error("product finished while nobody waits");

   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIVW)
      else $error("quotient finished while nobody waits");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD) |-> 32'(i_ff) < 32'(n_w))
      else $error("row counter past row count");

endmodule

`default_nettype wire

// ----- tb/sv/elastic_net_coordinate_sweep_checker.sv -----
module elastic_net_coordinate_sweep_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [2:0]         req_action,
   input  logic [7:0]         req_row_index,
   input  logic [3:0]         req_col_index,
   input  logic signed [31:0] req_value,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [3:0]         rsp_coef_index,
   input  logic signed [31:0] rsp_coef_value,
   input  logic               rsp_last,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   output int                 fail_count,
   output int                 coefs_pending
);
   import encs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NR = MAX_ROWS_DEF;
   localparam int NC = MAX_COLS_DEF;

   typedef struct packed {
      logic [3:0]         idx;
      logic signed [31:0] val;
      logic               lst;
   } coef_item_type;

   coef_item_type coef_due[$];

   logic signed [31:0] x_mat [NC][NR];
   logic signed [31:0] y_vec [NR];
   logic signed [47:0] resid [NR];
   logic signed [31:0] beta [NC];
   logic signed [31:0] wgt [NC];
   logic signed [63:0] norm_sq [NC];

   logic [31:0] lambda_r;
   logic [16:0] alpha_r;
   logic [8:0]  rows_r;
   logic [4:0]  cols_r;

   function automatic logic [63:0] abs64(input logic signed [63:0] a);
      return a[63] ? (~a + 64'd1) : a;
   endfunction

   // exact product, shifted by 16 toward zero, saturated to +-(2^63-1)
   function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                               input logic signed [31:0] b);
      logic [127:0] ua, ub, pr;
      logic neg;
      ua = {64'd0, abs64(a)};
      ub = {96'd0, (b[31] ? (~b + 32'd1) : b)};
      pr = (ua * ub) >> 16;
      if (pr > 128'h7FFF_FFFF_FFFF_FFFF) pr = 128'h7FFF_FFFF_FFFF_FFFF;
      neg = a[63] ^ b[31];
      return neg ? -$signed(pr[63:0]) : $signed(pr[63:0]);
   endfunction

   function automatic logic signed [63:0] qadd(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? S64MIN : S64MAX;
      return s[63:0];
   endfunction

   function automatic logic signed [47:0] clip48(input logic signed [64:0] s);
      if (s > 65'sh7FFF_FFFF_FFFF) return S48MAX;
      if (s < -65'sh8000_0000_0000) return S48MIN;
      return s[47:0];
   endfunction

   task automatic sweep_predict();
      int n, p, i, j;
      logic [16:0] al;
      logic signed [63:0] l1, l2, s, z, den, pen, pr;
      logic [63:0] az, ap, m, qi;
      logic [79:0] q;
      logic signed [31:0] bnew;
      coef_item_type it;
      n  = (rows_r > NR) ? NR : rows_r;
      p  = (cols_r > NC) ? NC : cols_r;
      al = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
      l2 = $signed({16'd0, 48'((64'(lambda_r) * 64'(ALPHA_ONE - al)) >> 16)});
      l1 = $signed({16'd0, 48'((64'(lambda_r) * 64'(al)) >> 16)});
      for (j = 0; j < p; j++) begin
         s = 0;
         for (i = 0; i < n; i++) s = qadd(s, qmul(64'(x_mat[j][i]), x_mat[j][i]));
         norm_sq[j] = s;
      end
      for (i = 0; i < n; i++) resid[i] = 48'(y_vec[i]);
      for (j = 0; j < p; j++)
         for (i = 0; i < n; i++) begin
            pr = qmul(64'(x_mat[j][i]), beta[j]);
            resid[i] = clip48(65'(resid[i]) - 65'(pr));
         end
      for (j = 0; j < p; j++) begin
         z = 0;
         bnew = 0;
         for (i = 0; i < n; i++) begin
            pr = qmul(64'(x_mat[j][i]), beta[j]);
            resid[i] = clip48(65'(resid[i]) + 65'(pr));
         end
         for (i = 0; i < n; i++) z = qadd(z, qmul(64'(resid[i]), x_mat[j][i]));
         den = qadd(norm_sq[j], l2);
         if (den > 0 && z != 0) begin
            az  = abs64(z);
            pen = qmul(l1, wgt[j]);
            if (!pen[63]) begin
               m = (az > pen) ? az - pen : 64'd0;
            end else begin
               ap = abs64(pen);
               m  = (az > ~ap) ? '1 : az + ap;
            end
            if (m != 0) begin
               qi = m / den;
               if (qi >= 64'h1_0000) q = 80'h1_0000_0000;
               else q = {m, 16'd0} / {16'd0, den};
               if (!z[63]) bnew = (q > 80'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q[31:0];
               else bnew = (q > 80'h8000_0000) ? 32'sh8000_0000 : -$signed(q[31:0]);
            end
         end
         beta[j] = bnew;
         for (i = 0; i < n; i++) begin
            pr = qmul(64'(x_mat[j][i]), bnew);
            resid[i] = clip48(65'(resid[i]) - 65'(pr));
         end
         it.idx = 4'(j);
         it.val = bnew;
         it.lst = (j + 1 == p);
         coef_due.push_back(it);
      end
   endtask

   initial begin
      fail_count    = 0;
      coefs_pending = 0;
   end

   always @(posedge clock) begin
      coef_item_type want;
      if (reset) begin
         lambda_r = 0;
         alpha_r  = ALPHA_ONE;
         rows_r   = 9'd256;
         cols_r   = 5'd16;
         coef_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_LAMBDA: lambda_r = csr_wdata;
               CSR_ALPHA:  alpha_r  = csr_wdata[16:0];
               CSR_ROWS:   rows_r   = csr_wdata[8:0];
               CSR_COLS:   cols_r   = csr_wdata[4:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (coef_due.size() == 0) begin
               $error("coefficient with none due: index %0d value %0d",
                      rsp_coef_index, rsp_coef_value);
               fail_count++;
            end else begin
               want = coef_due.pop_front();
               if (rsp_coef_index !== want.idx) begin
                  $error("coef_index expected %0d actual %0d", want.idx, rsp_coef_index);
                  fail_count++;
               end
               if (rsp_coef_value !== want.val) begin
                  $error("coef_value expected %0d actual %0d", want.val, rsp_coef_value);
                  fail_count++;
               end
               if (rsp_last !== want.lst) begin
                  $error("last expected %0d actual %0d", want.lst, rsp_last);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            case (req_action)
               ACT_MATRIX:   x_mat[req_col_index][req_row_index] = req_value;
               ACT_RESPONSE: y_vec[req_row_index] = req_value;
               ACT_COEF:     beta[req_col_index] = req_value;
               ACT_WEIGHT:   wgt[req_col_index] = req_value;
               ACT_START:    sweep_predict();
               default: ;
            endcase
         end
      end
      coefs_pending = coef_due.size();
   end
endmodule

// ----- tb/sv/elastic_net_coordinate_sweep_tb.sv -----
module elastic_net_coordinate_sweep_tb;
   import encs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 500000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [2:0]         req_action = '0;
   logic [7:0]         req_row_index = '0;
   logic [3:0]         req_col_index = '0;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [3:0]         rsp_coef_index;
   logic signed [31:0] rsp_coef_value;
   logic               rsp_last;
   logic               csr_we = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [31:0]        csr_wdata = '0;

   int fail_count;
   int coefs_pending;
   int quiet_cycles = 0;
   int items = 0;
   int n_used = 256;
   int p_used = 16;
   int stall_left = 0;
   bit no_idle = 0;

   // which store entries hold a loaded value
   bit mat_set [16][256];
   bit resp_set [256];
   bit coef_set [16];
   bit wgt_set [16];

   always #6 clock = ~clock;

   elastic_net_coordinate_sweep DUT (.*);

   elastic_net_coordinate_sweep_checker checker_i (.*);

   always @(posedge clock) begin
      if (no_idle || reset) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if ($urandom_range(0, 6) == 0) begin
         rsp_ready <= 1'b0;
         stall_left = $urandom_range(0, 3);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("elastic_net_coordinate_sweep_tb NOT OK");
         $finish;
      end
   end

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $signed(32'($urandom_range(0, 1 << 20))) - 32'sd524288;
         2: case ($urandom_range(0, 3))
               0: return 32'sh7FFF_FFFF;
               1: return 32'sh8000_0000;
               2: return 32'sh0001_0000;
               default: return 0;
            endcase
         default: return $signed(32'($urandom_range(0, 1 << 25))) - 32'sd16777216;
      endcase
   endfunction

   task automatic send(input logic [2:0] act, input int row, input int col,
                       input logic signed [31:0] val);
      if (!no_idle && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_action    <= act;
      req_row_index <= 8'(row);
      req_col_index <= 4'(col);
      req_value     <= val;
      req_valid     <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      case (act)
         ACT_MATRIX:   mat_set[col][row] = 1;
         ACT_RESPONSE: resp_set[row] = 1;
         ACT_COEF:     coef_set[col] = 1;
         ACT_WEIGHT:   wgt_set[col] = 1;
         default: ;
      endcase
      if (act <= ACT_START) items++;
   endtask

   // hold the request side until every coefficient is back and the sweep has drained
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (coefs_pending != 0) @(posedge clock);
      repeat (32 * n_used + 100) @(posedge clock);
   endtask

   task automatic write_cfg(input logic [31:0] lam, input logic [16:0] alp,
                            input int rows, input int cols);
      logic [31:0] vals [4];
      vals = '{lam, 32'(alp), 32'(rows), 32'(cols)};
      for (int k = 0; k < 4; k++) begin
         csr_we    <= 1'b1;
         csr_index <= 2'(k);
         csr_wdata <= vals[k];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      n_used = (rows > 256) ? 256 : rows;
      p_used = (cols > 16) ? 16 : cols;
   endtask

   // load whatever the coming sweep reads that was never loaded
   task automatic fill_gaps();
      for (int j = 0; j < p_used; j++)
         for (int i = 0; i < n_used; i++)
            if (!mat_set[j][i]) send(ACT_MATRIX, i, j, pick_value());
      for (int i = 0; i < n_used; i++)
         if (!resp_set[i]) send(ACT_RESPONSE, i, 0, pick_value());
      for (int j = 0; j < p_used; j++) begin
         if (!coef_set[j]) send(ACT_COEF, 0, j, pick_value());
         if (!wgt_set[j]) send(ACT_WEIGHT, 0, j, pick_value());
      end
   endtask

   task automatic random_phase();
      logic [31:0] lam;
      logic [16:0] alp;
      int rows, cols, r;
      case ($urandom_range(0, 9))
         0: rows = 0;
         1: rows = $urandom_range(13, 40);
         default: rows = $urandom_range(1, 12);
      endcase
      case ($urandom_range(0, 9))
         0: cols = 0;
         1: cols = $urandom_range(5, 16);
         default: cols = $urandom_range(1, 4);
      endcase
      case ($urandom_range(0, 4))
         0: lam = 0;
         1: lam = '1;
         2: lam = $urandom;
         default: lam = $urandom_range(0, 1 << 18);
      endcase
      case ($urandom_range(0, 4))
         0: alp = 0;
         1: alp = ALPHA_ONE;
         2: alp = $urandom_range(65537, 131071);
         default: alp = $urandom_range(0, 65536);
      endcase
      settle();
      write_cfg(lam, alp, rows, cols);
      repeat ($urandom_range(3, 20)) begin
         r = $urandom_range(0, 9);
         if (r == 0) send(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom);
         else if (r == 1) send(3'($urandom_range(0, 3)), $urandom_range(0, 255),
                               $urandom_range(0, 15), pick_value());
         else send(3'($urandom_range(0, 3)), $urandom_range(0, (n_used > 0) ? n_used - 1 : 0),
                   $urandom_range(0, (p_used > 0) ? p_used - 1 : 0), pick_value());
      end
      fill_gaps();
      send(ACT_START, $urandom, $urandom, $urandom);
      if ($urandom_range(0, 2) == 0) send(ACT_START, $urandom, $urandom, $urandom);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero column: zero correlation and, with no penalty, a zero denominator
      write_cfg(0, ALPHA_ONE, 4, 2);
      for (int i = 0; i < 4; i++) send(ACT_MATRIX, i, 0, 0);
      send(ACT_MATRIX, 0, 1, 32'sh7FFF_FFFF);
      send(ACT_MATRIX, 1, 1, 32'sh8000_0000);
      send(ACT_MATRIX, 2, 1, 1);
      send(ACT_MATRIX, 3, 1, -1);
      send(ACT_RESPONSE, 0, 0, 32'sh7FFF_FFFF);
      send(ACT_RESPONSE, 1, 0, 32'sh8000_0000);
      send(ACT_RESPONSE, 2, 0, 0);
      send(ACT_RESPONSE, 3, 0, 32'sh0001_2345);
      send(ACT_COEF, 0, 0, 32'sh8000_0000);
      send(ACT_COEF, 0, 1, 32'sh7FFF_FFFF);
      send(ACT_WEIGHT, 0, 0, -32'sd65536);
      send(ACT_WEIGHT, 0, 1, 32'sh8000_0000);
      send(3'd5, 255, 15, 32'sh7FFF_FFFF);
      send(3'd6, 0, 0, 0);
      send(3'd7, 170, 5, 32'sh5555_5555);
      send(ACT_START, 0, 0, 0);
      settle();
      write_cfg('1, 0, 4, 2);
      send(ACT_START, 0, 0, 0);
      settle();
      write_cfg('1, 17'h1FFFF, 0, 2);
      send(ACT_START, 0, 0, 0);
      settle();
      write_cfg(32'h0001_0000, 17'd32768, 4, 0);
      send(ACT_START, 0, 0, 0);

      while (items < 330) random_phase();

      // column count and alpha above their range clamp
      settle();
      write_cfg($urandom, 17'h1FFFF, 1, 31);
      fill_gaps();
      send(ACT_START, 0, 0, 0);

      settle();
      no_idle = 1;
      repeat (3) random_phase();

      req_valid <= 1'b0;
      @(posedge clock);
      while (coefs_pending != 0) @(posedge clock);
      repeat (32 * n_used + 100) @(posedge clock);
      if (fail_count == 0) begin
         $display("elastic_net_coordinate_sweep_tb OK");
      end else begin
         $display("elastic_net_coordinate_sweep_tb NOT OK");
      end
      $finish;
   end
endmodule

// ----- sim.f -----
rtl/encs_pkg.sv
rtl/encs_mulq.sv
rtl/encs_div.sv
rtl/elastic_net_coordinate_sweep.sv
tb/sv/elastic_net_coordinate_sweep_checker.sv
tb/sv/elastic_net_coordinate_sweep_tb.sv
